FILE: rtl/core/cre_pkg.sv
// types and constants shared by the carryless range encoder
package cre_pkg;

  localparam logic [31:0] RC_TOP_VAL  = 32'h0100_0000;
  localparam logic [31:0] RC_BOT_VAL  = 32'h0001_0000;
  localparam logic [31:0] RANGE_RESET = 32'hFFFF_FFFF;
  localparam int unsigned MAX_SHIFTS  = 4;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] cum;
    logic [15:0] freq;
    logic [15:0] tot;
  } cre_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } cre_out_t;

endpackage

FILE: rtl/core/carryless_range_encoder.sv
// carryless range encoder: bit-serial divide and multiply, byte-serial renormalization
// encode runs restoring division (one quotient bit a cycle), then shift-add multiply
//   (one bit of cum and freq a cycle), an add step and byte-serial renormalization,
//   which can stall on out
// flush emits four bytes of low; an illegal interval gives one error beat
// one item at a time: in_ready is high only while the coder waits for an item
// rst_n (synchronous, active low) sets low to zero and range to all ones
module carryless_range_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cre_pkg::cre_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cre_pkg::cre_out_t out_data
);
  import cre_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ERR    = 3'd1;
  localparam logic [2:0] ST_FLUSH  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_RENORM = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] range_r, range_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [15:0] cum_r, cum_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic [31:0] acc_c_r, acc_c_nxt;
  logic [31:0] acc_f_r, acc_f_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic        out_valid_r, out_valid_nxt;
  cre_out_t    out_r, out_nxt;

  logic        slot_free;
  logic        bad_interval;
  logic [16:0] trial;
  logic        trial_ge;
  logic [16:0] trial_sub;
  logic [31:0] hi;
  logic        top_eq;
  logic        bot_low;
  logic        do_shift;
  logic [31:0] cut_range;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // interval legality check
  assign bad_interval = (in_data.tot == 16'd0) || (in_data.freq == 16'd0) ||
                        (({1'b0, in_data.cum} + {1'b0, in_data.freq}) > {1'b0, in_data.tot});

  // restoring division step
  assign trial     = {rem_r, dvd_r[31]};
  assign trial_ge  = trial >= {1'b0, tot_r};
  assign trial_sub = trial - {1'b0, tot_r};

  // renormalization test
  assign hi        = low_r + range_r;
  assign top_eq    = (low_r ^ hi) < RC_TOP_VAL;
  assign bot_low   = range_r < RC_BOT_VAL;
  assign do_shift  = (top_eq || bot_low) && (cnt_r[2:0] != 3'(MAX_SHIFTS));
  assign cut_range = top_eq ? range_r : ((32'd0 - low_r) & (RC_BOT_VAL - 32'd1));

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    low_nxt        = low_r;
    range_nxt      = range_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    tot_nxt        = tot_r;
    cum_nxt        = cum_r;
    freq_nxt       = freq_r;
    acc_c_nxt      = acc_c_r;
    acc_f_nxt      = acc_f_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt = 5'd0;
          if (in_data.mode == MODE_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else if (bad_interval) begin
            state_nxt = ST_ERR;
          end else begin
            rem_nxt   = 16'd0;
            dvd_nxt   = range_r;
            tot_nxt   = in_data.tot;
            cum_nxt   = in_data.cum;
            freq_nxt  = in_data.freq;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.out_byte = 8'd0;
          out_nxt.last     = 1'b1;
          out_nxt.error    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      // four bytes of low, then back to the reset interval
      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.out_byte = low_r[31:24];
          out_nxt.last     = (cnt_r[1:0] == 2'd3);
          out_nxt.error    = 1'b0;
          low_nxt          = {low_r[23:0], 8'd0};
          cnt_nxt          = cnt_r + 5'd1;
          if (cnt_r[1:0] == 2'd3) begin
            low_nxt   = 32'd0;
            range_nxt = RANGE_RESET;
            state_nxt = ST_IDLE;
          end
        end
      end

      // one quotient bit per cycle
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_sub[15:0] : trial[15:0];
        dvd_nxt = {dvd_r[30:0], trial_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          cnt_nxt   = 5'd0;
          acc_c_nxt = 32'd0;
          acc_f_nxt = 32'd0;
          state_nxt = ST_MUL;
        end
      end

      // shift-add of cum and freq against the quotient, msb first
      ST_MUL: begin
        acc_c_nxt = {acc_c_r[30:0], 1'b0} + (cum_r[15] ? dvd_r : 32'd0);
        acc_f_nxt = {acc_f_r[30:0], 1'b0} + (freq_r[15] ? dvd_r : 32'd0);
        cum_nxt   = {cum_r[14:0], 1'b0};
        freq_nxt  = {freq_r[14:0], 1'b0};
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r[3:0] == 4'd15) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        low_nxt   = low_r + acc_c_r;
        range_nxt = acc_f_r;
        cnt_nxt   = 5'd0;
        state_nxt = ST_RENORM;
      end

      // one byte shift per cycle unless out stalls; held byte sent after next decision
      ST_RENORM: begin
        if (do_shift) begin
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_valid_nxt    = 1'b1;
              out_nxt.out_byte = pend_byte_r;
              out_nxt.last     = 1'b0;
              out_nxt.error    = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_byte_nxt  = low_r[31:24];
            low_nxt        = {low_r[23:0], 8'd0};
            range_nxt      = {cut_range[23:0], 8'd0};
            cnt_nxt        = cnt_r + 5'd1;
          end
        end else if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.out_byte = pend_byte_r;
          out_nxt.last     = 1'b1;
          out_nxt.error    = 1'b0;
          pend_valid_nxt   = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= 5'd0;
      low_r        <= 32'd0;
      range_r      <= RANGE_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      low_r        <= low_nxt;
      range_r      <= range_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    tot_r       <= tot_nxt;
    cum_r       <= cum_nxt;
    freq_r      <= freq_nxt;
    acc_c_r     <= acc_c_nxt;
    acc_f_r     <= acc_f_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_r       <= out_nxt;
  end

endmodule
